// File: rtl/form_urlencoded_decoder_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the form body decoder
// Checks are compiled in simulation only; synthesis sees empty bodies.
// ---------------------------------------------------------------------------
`ifndef FORM_URLENCODED_DECODER_CORE_DEFINES_SVH
`define FORM_URLENCODED_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge out of reset.
`define FUD_ASSERT_IMPLY(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("fud assertion failed");
// Next-cycle implication, checked on every rising clock edge out of reset.
`define FUD_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("fud assertion failed");
`else
`define FUD_ASSERT_IMPLY(label, pre, post)
`define FUD_ASSERT_NEXT(label, pre, post)
`endif

`endif

// File: rtl/fud_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fud_pkg
// Shared types and constants of the form body decoder.
// ---------------------------------------------------------------------------
package fud_pkg;

   // Result kinds
   localparam logic [1:0] KIND_NAME  = 2'd0;
   localparam logic [1:0] KIND_VALUE = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   // Characters of the encoding
   localparam logic [7:0] CHAR_AMP   = 8'h26;
   localparam logic [7:0] CHAR_EQ    = 8'h3D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_PCT   = 8'h25;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] HEX_TEN    = 8'd10;

   // Result queue
   localparam int QUEUE_DEPTH = 4;
   localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      ESC_IDLE = 3'b001,
      ESC_HIGH = 3'b010,
      ESC_LOW  = 3'b100
   } esc_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       is_final;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic       pair_error;
      logic       body_done;
   } rsp_type;

   typedef struct packed {
      logic       in_value_part;
      esc_type    escape_phase;
      logic [7:0] partial_byte;
      logic       error_seen;
   } pair_state_type;

   // Up to two results per input byte; the second is used only with the first.
   typedef struct packed {
      logic    first_valid;
      rsp_type first;
      logic    second_valid;
      rsp_type second;
   } emit_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
   } queue_status_type;

endpackage

// File: rtl/form_urlencoded_decoder_core.sv
`timescale 1ns / 1ps
// Path: an accepted byte is registered in the input stage, its results in the result queue.
// Throughput: one byte per cycle while the queue has room for two results; a final
// byte with both a byte result and a pair end pushes two, drained by the single read port.
// Reset: synchronous, active high; clears the input stage, the pair state and the
// result queue. Ready returns in the first cycle after reset.
`include "form_urlencoded_decoder_core_defines.svh"
// ---------------------------------------------------------------------------
// form_urlencoded_decoder_core
// Streaming decoder for form-encoded bodies: splits pairs at '&', name and
// value at the first '=', and decodes '+' and percent escapes in the value.
// ---------------------------------------------------------------------------
module form_urlencoded_decoder_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fud_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fud_pkg::rsp_type rsp_data
);

   // Decode only when the queue has room for the worst case of two results,
   // so the decision never waits on the result side in the same cycle.
   localparam logic [fud_pkg::LEVEL_W-1:0] ROOM_LIMIT =
      fud_pkg::LEVEL_W'(fud_pkg::QUEUE_DEPTH - 2);

   localparam fud_pkg::pair_state_type PAIR_RESET = '{
      in_value_part: 1'b0,
      escape_phase:  fud_pkg::ESC_IDLE,
      partial_byte:  8'h00,
      error_seen:    1'b0
   };

   logic                      in_valid_ff, in_valid_in;
   fud_pkg::req_type          in_data_ff;
   fud_pkg::pair_state_type   pair_ff, pair_in;
   fud_pkg::pair_state_type   pair_nxt;
   fud_pkg::emit_type         emit;
   fud_pkg::emit_type         push;
   fud_pkg::queue_status_type q_status;
   logic                      process;
   logic                      req_xfer;

   // ---- input stage: hold one byte until the queue can take its results ----
   assign process   = in_valid_ff & (q_status.level <= ROOM_LIMIT);
   assign req_ready = ~in_valid_ff | process;
   assign req_xfer  = req_valid & req_ready;

   always_comb begin
      in_valid_in = req_xfer | (in_valid_ff & ~process);
      pair_in     = process ? pair_nxt : pair_ff;
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pair_ff     <= PAIR_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         pair_ff     <= pair_in;
      end
   end

   // ---- per-byte decision ----
   fud_decode u_decode (
      .item      (in_data_ff),
      .state_cur (pair_ff),
      .state_nxt (pair_nxt),
      .emit      (emit)
   );

   // drop the results unless the byte is actually consumed this cycle
   always_comb begin
      push              = emit;
      push.first_valid  = emit.first_valid & process;
      push.second_valid = emit.second_valid & process;
   end

   // ---- result queue: parts the output handshake from the decode ----
   fud_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .status    (q_status)
   );

   // ---- checks ----
   // queue never overfills
   `FUD_ASSERT_IMPLY(a_queue_bound, 1'b1, q_status.level <= fud_pkg::LEVEL_W'(fud_pkg::QUEUE_DEPTH))
   // pair end markers carry a zero byte
   `FUD_ASSERT_IMPLY(a_end_zero, rsp_valid && rsp_data.kind == fud_pkg::KIND_END, rsp_data.out_byte == 8'h00)
   // byte results carry no pair flags
   `FUD_ASSERT_IMPLY(a_byte_flags, rsp_valid && rsp_data.kind != fud_pkg::KIND_END, !rsp_data.pair_error && !rsp_data.body_done)
   // a final byte leaves the pair state cleared
   `FUD_ASSERT_NEXT(a_final_clears, process && in_data_ff.is_final, !pair_ff.in_value_part && pair_ff.escape_phase == fud_pkg::ESC_IDLE && !pair_ff.error_seen)

endmodule

// File: rtl/fud_decode.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fud_decode
// Per-byte decision: next pair state and the results the byte gives.
// ---------------------------------------------------------------------------
module fud_decode (
   input  fud_pkg::req_type        item,
   input  fud_pkg::pair_state_type state_cur,
   output fud_pkg::pair_state_type state_nxt,
   output fud_pkg::emit_type       emit
);

   localparam fud_pkg::pair_state_type PAIR_RESET = '{
      in_value_part: 1'b0,
      escape_phase:  fud_pkg::ESC_IDLE,
      partial_byte:  8'h00,
      error_seen:    1'b0
   };

   always_comb begin
      logic [7:0]              c;
      logic [7:0]              nib;
      logic                    byte_valid;
      logic [7:0]              byte_val;
      logic [1:0]              byte_kind;
      logic                    end_valid;
      logic                    end_err;
      fud_pkg::pair_state_type nxt;
      fud_pkg::rsp_type        byte_rsp;
      fud_pkg::rsp_type        end_rsp;

      c          = item.in_byte;
      nib        = (c >= fud_pkg::CHAR_A) ? (c - fud_pkg::CHAR_A + fud_pkg::HEX_TEN)
                                          : (c - fud_pkg::CHAR_0);
      byte_valid = 1'b0;
      byte_val   = c;
      byte_kind  = fud_pkg::KIND_VALUE;
      end_valid  = 1'b0;
      end_err    = 1'b0;
      nxt        = state_cur;

      if (c == fud_pkg::CHAR_AMP) begin
         // pair ends here, any pending escape counts as cut short
         end_valid = 1'b1;
         end_err   = state_cur.error_seen | (state_cur.escape_phase != fud_pkg::ESC_IDLE);
         nxt       = PAIR_RESET;
      end else begin
         if (!state_cur.in_value_part) begin
            if (c == fud_pkg::CHAR_EQ) begin
               nxt.in_value_part = 1'b1;
            end else begin
               byte_valid = 1'b1;
               byte_kind  = fud_pkg::KIND_NAME;
            end
         end else if (c == fud_pkg::CHAR_EQ) begin
            nxt.error_seen = 1'b1;
         end else begin
            unique case (state_cur.escape_phase)
               fud_pkg::ESC_HIGH: begin
                  nxt.partial_byte = {nib[3:0], 4'h0};
                  nxt.escape_phase = fud_pkg::ESC_LOW;
               end
               fud_pkg::ESC_LOW: begin
                  byte_valid       = 1'b1;
                  byte_val         = state_cur.partial_byte + nib;
                  nxt.escape_phase = fud_pkg::ESC_IDLE;
                  nxt.partial_byte = 8'h00;
               end
               fud_pkg::ESC_IDLE: begin
                  if (c == fud_pkg::CHAR_PCT) begin
                     nxt.escape_phase = fud_pkg::ESC_HIGH;
                     nxt.partial_byte = 8'h00;
                  end else if (c == fud_pkg::CHAR_PLUS) begin
                     byte_valid = 1'b1;
                     byte_val   = fud_pkg::CHAR_SPACE;
                  end else begin
                     byte_valid = 1'b1;
                  end
               end
               default: begin
                  nxt.escape_phase = fud_pkg::ESC_IDLE;
               end
            endcase
         end

         if (item.is_final) begin
            end_valid = 1'b1;
            end_err   = nxt.error_seen | (nxt.escape_phase != fud_pkg::ESC_IDLE);
            nxt       = PAIR_RESET;
         end
      end

      byte_rsp = '{out_byte: byte_val, kind: byte_kind, pair_error: 1'b0, body_done: 1'b0};
      end_rsp  = '{out_byte: 8'h00, kind: fud_pkg::KIND_END, pair_error: end_err,
                   body_done: item.is_final};

      state_nxt = nxt;
      // byte result goes first, the pair end after it
      emit.first_valid  = byte_valid | end_valid;
      emit.first        = byte_valid ? byte_rsp : end_rsp;
      emit.second_valid = byte_valid & end_valid;
      emit.second       = end_rsp;
   end

endmodule

// File: rtl/fud_rsp_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fud_rsp_queue
// Small result queue: up to two writes and one read per cycle.
// ---------------------------------------------------------------------------
module fud_rsp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  fud_pkg::emit_type         push,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output fud_pkg::rsp_type          rsp_data,
   output fud_pkg::queue_status_type status
);

   localparam int PTR_W = $clog2(fud_pkg::QUEUE_DEPTH);

   fud_pkg::rsp_type             entry_ff [fud_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]             wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]             rd_ptr_ff, rd_ptr_in;
   logic [fud_pkg::LEVEL_W-1:0]  level_ff, level_in;
   logic                         pop;
   logic [PTR_W-1:0]             wr_ptr_next;

   assign rsp_valid   = (level_ff != '0);
   assign rsp_data    = entry_ff[rd_ptr_ff];
   assign pop         = rsp_valid & rsp_ready;
   assign wr_ptr_next = wr_ptr_ff + PTR_W'(1);
   assign status.level = level_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.first_valid) + PTR_W'(push.second_valid);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      level_in  = level_ff + fud_pkg::LEVEL_W'(push.first_valid)
                           + fud_pkg::LEVEL_W'(push.second_valid)
                           - fud_pkg::LEVEL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.second_valid) begin
         entry_ff[wr_ptr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule
